// File: rtl/tkst_pkg.sv
// Shared types for the top-k sorted table: row layout, controller states and control buses.
`default_nettype none
package tkst_pkg;

    localparam int unsigned KeyWidth  = 32;
    localparam int unsigned RankWidth = 3;

    typedef struct packed {
        logic [KeyWidth-1:0] tag;
        logic [KeyWidth-1:0] survival_time;
        logic [KeyWidth-1:0] score;
    } row_t;

    localparam int unsigned RowWidth = $bits(row_t);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last;
    } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/top_k_sorted_table_insert_core.sv
// Top-k sorted table: inserts scored entries in rank order and streams out the whole table.
//
// Each input transaction carries one entry (score, survival time, tag). The
// entry is placed after every stored row that is not strictly worse, and
// the table is cut to TABLE_DEPTH rows. After each insert the complete
// ranked table is sent on the master side, one transaction per row, best
// row first, with tlast on the final row.
// The entry is accepted, then one row is merged and written back per cycle
// through the table RAM while the output register is free to take it.
// The first row passes through the RAM read and the output register before
// it is presented. A new entry is taken only once every row of the
// previous table has been issued; the last row may still be waiting in the
// output register at that point.
// When the receiver stalls, the row walk pauses and resumes without loss.
// Reset empties the table; no clearing pass is needed.
`default_nettype none
module top_k_sorted_table_insert_core #(
    parameter int unsigned TABLE_DEPTH = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // score[31:0], survival_time[63:32], tag[95:64]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // rank[2:0], row_score[34:3],
                                         // row_survival_time[66:35], row_tag[98:67]
    output logic              m_tlast
);
    import tkst_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tkst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .cmd     (cmd),
        .status  (status)
    );

    tkst_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule
`default_nettype wire

// File: rtl/tkst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tkst_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/tkst_datapath.sv
// Datapath of the top-k sorted table: table RAM, merge of the new entry and the output register.
`default_nettype none
module tkst_datapath #(
    parameter int unsigned TABLE_DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire tkst_pkg::dp_cmd_t        cmd,
    output tkst_pkg::dp_status_t          status,
    input  wire logic [95:0]              s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [103:0]                  m_tdata,
    output logic                          m_tlast
);
    import tkst_pkg::*;

    localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CntW-1:0] FullCount = CntW'(TABLE_DEPTH);

    row_t            new_reg;
    row_t            carry_reg;
    row_t            old_row;
    row_t            out_row;
    row_t            out_row_reg;
    logic [RowWidth-1:0] ram_rdata;
    logic [IdxW-1:0] idx_reg;
    logic [IdxW-1:0] out_idx_reg;
    logic [IdxW-1:0] raddr;
    logic [CntW-1:0] cnt_reg;
    logic            was_full_reg;
    logic            inserted_reg;
    logic            out_last_reg;
    logic            last;
    logic            beyond;
    logic            worse;
    logic            take_new;

    tkst_ram #(
        .WIDTH(RowWidth),
        .DEPTH(TABLE_DEPTH),
        .AW   (IdxW)
    ) u_table (
        .aclk (aclk),
        .we   (cmd.step),
        .waddr(idx_reg),
        .wdata(out_row),
        .raddr(raddr),
        .rdata(ram_rdata)
    );

    assign old_row = row_t'(ram_rdata);

    // Read the first row on load, one row ahead while a row is retired, otherwise reread the current one.
    always_comb begin
        if (cmd.load) begin
            raddr = '0;
        end else if (cmd.step) begin
            raddr = IdxW'(idx_reg + 1'b1);
        end else begin
            raddr = idx_reg;
        end
    end

    assign last   = (CntW'(idx_reg) + CntW'(1)) == cnt_reg;
    // The row just past the old table end holds nothing yet.
    assign beyond = last && !was_full_reg;
    assign worse  = (old_row.score < new_reg.score) ||
                    ((old_row.score == new_reg.score) &&
                     (old_row.survival_time < new_reg.survival_time));
    assign take_new = !inserted_reg && (beyond || worse);

    always_comb begin
        if (inserted_reg) begin
            out_row = carry_reg;
        end else if (take_new) begin
            out_row = new_reg;
        end else begin
            out_row = old_row;
        end
    end

    assign status.out_free = !m_tvalid || m_tready;
    assign status.last     = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            was_full_reg <= 1'b0;
            inserted_reg <= 1'b0;
            idx_reg      <= '0;
            m_tvalid     <= 1'b0;
        end else begin
            if (cmd.load) begin
                was_full_reg <= (cnt_reg == FullCount);
                if (cnt_reg != FullCount) begin
                    cnt_reg <= cnt_reg + CntW'(1);
                end
                inserted_reg <= 1'b0;
                idx_reg      <= '0;
            end
            if (cmd.step) begin
                inserted_reg <= inserted_reg || take_new;
                idx_reg      <= IdxW'(idx_reg + 1'b1);
                m_tvalid     <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            new_reg <= row_t'(s_tdata);
        end
        if (cmd.step) begin
            carry_reg    <= old_row;
            out_row_reg  <= out_row;
            out_idx_reg  <= idx_reg;
            out_last_reg <= last;
        end
    end

    assign m_tdata = {5'b0, out_row_reg.tag, out_row_reg.survival_time, out_row_reg.score,
                      RankWidth'(out_idx_reg)};
    assign m_tlast = out_last_reg;

endmodule
`default_nettype wire

// File: rtl/tkst_ctrl.sv
// Controller of the top-k sorted table: takes one entry, then walks the table row by row.
`default_nettype none
module tkst_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output tkst_pkg::dp_cmd_t         cmd,
    input  wire tkst_pkg::dp_status_t status
);
    import tkst_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.step = 1'b1;
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
